@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define ASSERT_IMPLY(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

@@ rtl/core/hsdp_pkg.sv @@
// Shared types, constants and functions of the SPS dimension parser.
package hsdp_pkg;

  localparam int DIM_BITS = 16;
  localparam logic [4:0] GOLOMB_ZERO_CAP = 5'd31;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CALC_W = 40;
  localparam logic signed [CALC_W-1:0] DIM_LIM = CALC_W'((64'd1 << DIM_BITS) - 64'd1);
  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [7:0] EMUL_BYTE = 8'h03;
  localparam logic [7:0] SCALE_INIT = 8'd8;

  typedef enum logic [2:0] {
    HP_START, HP_ZERO1, HP_ZERO2, HP_ZERO3, HP_HEADER, HP_BODY, HP_FAIL
  } hphase_t;

  typedef enum logic [5:0] {
    ST_PROFILE, ST_CONSTRAINT, ST_LEVEL, ST_SPS_ID, ST_CHROMA, ST_SEP_PLANE,
    ST_DEPTH_L, ST_DEPTH_C, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DELTA,
    ST_LOG2_FN, ST_POC_TYPE, ST_POC_LSB, ST_DPIC_FLAG, ST_OFF_NONREF,
    ST_OFF_TB, ST_CYCLE_N, ST_CYCLE_OFF, ST_MAX_REF, ST_GAPS, ST_WIDTH,
    ST_HEIGHT, ST_FMO, ST_MBAFF, ST_DIRECT, ST_CROP_FLAG, ST_CROP_L,
    ST_CROP_R, ST_CROP_T, ST_CROP_B, ST_DONE
  } step_t;

  typedef enum logic [2:0] {
    B_IDLE, B_BITS, B_END, B_PAD, B_CALC, B_SUB, B_OUT
  } bstate_t;

  typedef struct packed {
    logic [7:0] data;
    logic       feed;
    logic       last;
    logic       body;
  } q_entry_t;

  function automatic logic [4:0] fixed_width(input step_t s);
    case (s)
      ST_PROFILE, ST_CONSTRAINT, ST_LEVEL: fixed_width = 5'd8;
      ST_SEP_PLANE, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DPIC_FLAG, ST_GAPS,
      ST_FMO, ST_MBAFF, ST_DIRECT, ST_CROP_FLAG: fixed_width = 5'd1;
      default: fixed_width = 5'd0;
    endcase
  endfunction

  function automatic logic high_profile(input logic [7:0] p);
    high_profile = p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                             8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
  endfunction

endpackage

@@ rtl/core/hsdp_front.sv @@
// Front end: start code and NAL header checks, emulation-prevention removal.
module hsdp_front
  import hsdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] nal_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       in_stall,
  output logic       q_push,
  output q_entry_t   push_entry
);

  hphase_t    hp, hp_next, hp_after;
  logic [1:0] zero_run, zero_run_next, zr_after;
  logic       accept, emul;

  assign accept = in_valid && !q_full;
  assign emul = (hp == HP_BODY) && (zero_run >= 2'd2) && (nal_byte == EMUL_BYTE);

  always_comb begin
    hp_after = hp;
    case (hp)
      HP_START: begin
        if (nal_byte != 8'd0) begin
          hp_after = (nal_byte[4:0] == NAL_TYPE_SPS && !last_byte) ? HP_BODY : HP_FAIL;
        end else begin
          hp_after = HP_ZERO1;
        end
      end
      HP_ZERO1: hp_after = (nal_byte == 8'd0) ? HP_ZERO2 : HP_FAIL;
      HP_ZERO2: begin
        if (nal_byte == 8'd1) hp_after = HP_HEADER;
        else hp_after = (nal_byte == 8'd0) ? HP_ZERO3 : HP_FAIL;
      end
      HP_ZERO3: hp_after = (nal_byte == 8'd1) ? HP_HEADER : HP_FAIL;
      HP_HEADER: begin
        hp_after = (nal_byte[4:0] == NAL_TYPE_SPS && !last_byte) ? HP_BODY : HP_FAIL;
      end
      HP_BODY: hp_after = HP_BODY;
      default: hp_after = HP_FAIL;
    endcase
  end

  always_comb begin
    zr_after = zero_run;
    if (hp == HP_BODY) begin
      if (emul) zr_after = 2'd0;
      else if (nal_byte == 8'd0) zr_after = (zero_run < 2'd2) ? zero_run + 2'd1 : 2'd2;
      else zr_after = 2'd0;
    end
    hp_next = hp;
    zero_run_next = zero_run;
    if (accept) begin
      hp_next = last_byte ? HP_START : hp_after;
      zero_run_next = last_byte ? 2'd0 : zr_after;
    end
  end

  always_comb begin
    in_stall = q_full;
    q_push = accept;
    push_entry.data = nal_byte;
    push_entry.feed = (hp == HP_BODY) && !emul;
    push_entry.last = last_byte;
    push_entry.body = (hp_after == HP_BODY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hp <= HP_START;
      zero_run <= 2'd0;
    end else begin
      hp <= hp_next;
      zero_run <= zero_run_next;
    end
  end

endmodule

@@ rtl/core/hsdp_queue.sv @@
// Short queue of classified byte beats between the front and back ends.
module hsdp_queue
  import hsdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output logic     full,
  output logic     empty
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

@@ rtl/core/hsdp_back.sv @@
// Back end: bit-serial SPS syntax parser, dimension arithmetic and result register.
module hsdp_back
  import hsdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        ok,
  output logic [15:0] luma_width,
  output logic [15:0] luma_height
);

  bstate_t state, state_next;
  q_entry_t cur;
  logic [2:0] bitcnt;
  logic good;

  step_t step, step_n, tgt;
  logic [4:0]  gzc, gzc_n, bl, bl_n, fw;
  logic [31:0] acc, acc_n, v, loop_cnt, loop_n;
  logic [7:0]  profile, profile_n, scale_last, scale_last_n, vh8, d8, nxt;
  logic [1:0]  chroma, chroma_n;
  logic [3:0]  li, li_n, li_inc;
  logic        suf, suf_n, done;
  logic [31:0] sf [7];
  logic [31:0] sf_n [7];

  logic feed_en, feed_b, out_load;
  logic signed [CALC_W-1:0] bw, cwr, bh, chr, w_r, h_r;
  logic [32:0] s0p, s1p, sum34, sum56;
  logic        fields2, sw2, sh2, res_ok;

  // One Exp-Golomb or fixed-width bit step of the syntax parser.
  always_comb begin
    step_n = step; gzc_n = gzc; bl_n = bl; acc_n = acc; suf_n = suf;
    profile_n = profile; chroma_n = chroma; loop_n = loop_cnt;
    scale_last_n = scale_last; li_n = li;
    for (int i = 0; i < 7; i++) sf_n[i] = sf[i];
    done = 1'b0; v = '0; tgt = step;
    fw = fixed_width(step);
    li_inc = li + 4'd1;
    vh8 = 8'h00; d8 = 8'h00; nxt = 8'h00;
    if (feed_en && step != ST_DONE) begin
      if (fw != 5'd0) begin
        acc_n = {acc[30:0], feed_b};
        bl_n = bl - 5'd1;
        if (bl == 5'd1) begin
          done = 1'b1;
          v = acc_n;
        end
      end else if (!suf) begin
        if (!feed_b && gzc < GOLOMB_ZERO_CAP) begin
          gzc_n = gzc + 5'd1;
        end else if (gzc == 5'd0) begin
          done = 1'b1;
        end else begin
          suf_n = 1'b1;
          bl_n = gzc;
          acc_n = '0;
        end
      end else begin
        acc_n = {acc[30:0], feed_b};
        bl_n = bl - 5'd1;
        if (bl == 5'd1) begin
          done = 1'b1;
          v = ((32'd1 << gzc) - 32'd1) + acc_n;
        end
      end
      if (done) begin
        vh8 = v[8:1];
        d8 = v[0] ? vh8 + 8'd1 : ~vh8 + 8'd1;
        nxt = scale_last + d8;
        case (step)
          ST_PROFILE: begin
            profile_n = v[7:0];
            tgt = ST_CONSTRAINT;
          end
          ST_CONSTRAINT: tgt = ST_LEVEL;
          ST_LEVEL: tgt = ST_SPS_ID;
          ST_SPS_ID: tgt = high_profile(profile) ? ST_CHROMA : ST_LOG2_FN;
          ST_CHROMA: begin
            chroma_n = (v > 32'd3) ? 2'd0 : v[1:0];
            tgt = (chroma_n == 2'd3) ? ST_SEP_PLANE : ST_DEPTH_L;
          end
          ST_SEP_PLANE: tgt = ST_DEPTH_L;
          ST_DEPTH_L: tgt = ST_DEPTH_C;
          ST_DEPTH_C: tgt = ST_BYPASS;
          ST_BYPASS: tgt = ST_MATRIX;
          ST_MATRIX: begin
            li_n = 4'd0;
            tgt = (v != 32'd0) ? ST_LIST_FLAG : ST_LOG2_FN;
          end
          ST_LIST_FLAG: begin
            if (v != 32'd0) begin
              scale_last_n = SCALE_INIT;
              loop_n = '0;
              tgt = ST_DELTA;
            end else begin
              li_n = li_inc;
              tgt = (li_inc < ((chroma != 2'd3) ? 4'd8 : 4'd12)) ? ST_LIST_FLAG : ST_LOG2_FN;
            end
          end
          ST_DELTA: begin
            if (nxt != 8'd0) scale_last_n = nxt;
            loop_n = loop_cnt + 32'd1;
            if (nxt == 8'd0 || loop_n >= ((li < 4'd6) ? 32'd16 : 32'd64)) begin
              li_n = li_inc;
              tgt = (li_inc < ((chroma != 2'd3) ? 4'd8 : 4'd12)) ? ST_LIST_FLAG : ST_LOG2_FN;
            end else begin
              tgt = ST_DELTA;
            end
          end
          ST_LOG2_FN: tgt = ST_POC_TYPE;
          ST_POC_TYPE: begin
            if (v == 32'd0) tgt = ST_POC_LSB;
            else tgt = (v == 32'd1) ? ST_DPIC_FLAG : ST_MAX_REF;
          end
          ST_POC_LSB: tgt = ST_MAX_REF;
          ST_DPIC_FLAG: tgt = ST_OFF_NONREF;
          ST_OFF_NONREF: tgt = ST_OFF_TB;
          ST_OFF_TB: tgt = ST_CYCLE_N;
          ST_CYCLE_N: begin
            loop_n = v;
            tgt = (v == 32'd0) ? ST_MAX_REF : ST_CYCLE_OFF;
          end
          ST_CYCLE_OFF: begin
            loop_n = loop_cnt - 32'd1;
            tgt = (loop_n == 32'd0) ? ST_MAX_REF : ST_CYCLE_OFF;
          end
          ST_MAX_REF: tgt = ST_GAPS;
          ST_GAPS: tgt = ST_WIDTH;
          ST_WIDTH: begin
            sf_n[0] = v;
            tgt = ST_HEIGHT;
          end
          ST_HEIGHT: begin
            sf_n[1] = v;
            tgt = ST_FMO;
          end
          ST_FMO: begin
            sf_n[2] = {31'd0, v[0]};
            tgt = v[0] ? ST_DIRECT : ST_MBAFF;
          end
          ST_MBAFF: tgt = ST_DIRECT;
          ST_DIRECT: tgt = ST_CROP_FLAG;
          ST_CROP_FLAG: tgt = v[0] ? ST_CROP_L : ST_DONE;
          ST_CROP_L: begin
            sf_n[3] = v;
            tgt = ST_CROP_R;
          end
          ST_CROP_R: begin
            sf_n[4] = v;
            tgt = ST_CROP_T;
          end
          ST_CROP_T: begin
            sf_n[5] = v;
            tgt = ST_CROP_B;
          end
          ST_CROP_B: begin
            sf_n[6] = v;
            tgt = ST_DONE;
          end
          default: tgt = ST_DONE;
        endcase
        step_n = tgt;
        acc_n = '0;
        gzc_n = '0;
        suf_n = 1'b0;
        bl_n = fixed_width(tgt);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.feed) state_next = B_BITS;
          else if (head.last) state_next = B_END;
        end
      end
      B_BITS: begin
        if (bitcnt == 3'd7) state_next = cur.last ? B_END : B_IDLE;
      end
      B_END: begin
        state_next = (cur.body && step >= ST_CROP_L) ? B_PAD : B_OUT;
      end
      B_PAD: if (step == ST_DONE) state_next = B_CALC;
      B_CALC: state_next = B_SUB;
      B_SUB: state_next = B_OUT;
      B_OUT: if (out_load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == B_IDLE) && !q_empty;
    feed_en = (state == B_BITS) || (state == B_PAD);
    feed_b = (state == B_BITS) ? cur.data[3'd7 - bitcnt] : 1'b0;
    out_load = (state == B_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
      bitcnt <= 3'd0;
    end else if (state == B_BITS) begin
      bitcnt <= bitcnt + 3'd1;
    end
    if (state == B_END) good <= cur.body && step >= ST_CROP_L;
  end

  // Parser state returns to its start values after every result.
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      step <= ST_PROFILE;
      gzc <= '0;
      bl <= fixed_width(ST_PROFILE);
      acc <= '0;
      suf <= 1'b0;
      profile <= '0;
      chroma <= 2'd1;
      loop_cnt <= '0;
      scale_last <= SCALE_INIT;
      li <= '0;
      for (int i = 0; i < 7; i++) sf[i] <= '0;
    end else begin
      step <= step_n;
      gzc <= gzc_n;
      bl <= bl_n;
      acc <= acc_n;
      suf <= suf_n;
      profile <= profile_n;
      chroma <= chroma_n;
      loop_cnt <= loop_n;
      scale_last <= scale_last_n;
      li <= li_n;
      for (int i = 0; i < 7; i++) sf[i] <= sf_n[i];
    end
  end

  // Multiplications by 16, 2 and field count reduce to shifts.
  assign s0p = {1'b0, sf[0]} + 33'd1;
  assign s1p = {1'b0, sf[1]} + 33'd1;
  assign sum34 = {1'b0, sf[3]} + {1'b0, sf[4]};
  assign sum56 = {1'b0, sf[5]} + {1'b0, sf[6]};
  assign fields2 = (sf[2][0] == 1'b0);
  assign sw2 = (chroma == 2'd1) || (chroma == 2'd2);
  assign sh2 = (chroma == 2'd1);

  always_ff @(posedge clk) begin
    if (state == B_CALC) begin
      bw <= {3'd0, s0p, 4'd0};
      cwr <= sw2 ? {6'd0, sum34, 1'b0} : {7'd0, sum34};
      bh <= fields2 ? {2'd0, s1p, 5'd0} : {3'd0, s1p, 4'd0};
      chr <= {7'd0, sum56} << ({1'b0, sh2} + {1'b0, fields2});
    end
    if (state == B_SUB) begin
      w_r <= bw - cwr;
      h_r <= bh - chr;
    end
  end

  assign res_ok = good && (w_r >= 2) && (h_r >= 2) && (w_r <= DIM_LIM) && (h_r <= DIM_LIM);

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok <= res_ok;
      luma_width <= res_ok ? w_r[15:0] : 16'd0;
      luma_height <= res_ok ? h_r[15:0] : 16'd0;
    end
  end

endmodule

@@ rtl/core/h264_sps_dimension_parser.sv @@
// Top level of the H.264 SPS dimension parser.
// Each byte beat passes the front end combinationally into the queue; in the back end the
// syntax parser consumes one bit per cycle of a payload beat and pops the next beat only after all eight bits.
// On the last byte, zero bits pad out missing cropping fields, then the B_CALC and B_SUB
// arithmetic stages run before the result beat; a 4-beat queue decouples the ends.
// Reset (rst, synchronous) empties the queue, clears the result valid flag and restarts the parse.
`include "assert_macros.svh"
module h264_sps_dimension_parser
  import hsdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  nal_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [15:0] luma_width,
  output logic [15:0] luma_height
);

  q_entry_t push_entry, head;
  logic     q_push, q_pop, q_full, q_empty;

  hsdp_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .nal_byte(nal_byte),
    .last_byte(last_byte), .q_full(q_full), .in_stall(in_stall),
    .q_push(q_push), .push_entry(push_entry)
  );

  hsdp_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_entry(push_entry), .pop(q_pop),
    .head(head), .full(q_full), .empty(q_empty)
  );

  hsdp_back u_back (
    .clk(clk), .rst(rst), .head(head), .q_empty(q_empty), .q_pop(q_pop),
    .out_stall(out_stall), .out_valid(out_valid), .ok(ok),
    .luma_width(luma_width), .luma_height(luma_height)
  );

  `ASSERT_IMPLY(a_no_overflow, q_push, !q_full, "push into a full queue")
  `ASSERT_IMPLY(a_no_underflow, q_pop, !q_empty, "pop from an empty queue")
  `ASSERT_IMPLY(a_ok_dims, out_valid && ok, luma_width >= 16'd2 && luma_height >= 16'd2, "ok result with too small dimensions")
  `ASSERT_IMPLY(a_fail_zero, out_valid && !ok, luma_width == 16'd0 && luma_height == 16'd0, "failed result with nonzero dimensions")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the H.264 SPS dimension parser: byte beats in, dimension beats out.
module testbench
  import hsdp_pkg::*;
;

  typedef struct {
    bit          ok;
    logic [15:0] w;
    logic [15:0] h;
  } dims_t;

  typedef struct {
    logic [7:0] b;
    bit         last;
    bit         typed;
    dims_t      res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  nal_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        ok;
  logic [15:0] luma_width;
  logic [15:0] luma_height;

  h264_sps_dimension_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .nal_byte(nal_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .ok(ok), .luma_width(luma_width), .luma_height(luma_height)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dims_t      dims_q[$];
  row_t       dir_rows[$];
  logic [7:0] nal_q[$];
  bit         bitq[$];
  int         errors = 0;
  int         results_seen = 0;
  int         bytes_sent = 0;
  int         idle_cycles = 0;
  bit         quiet = 0;
  bit         hold_req = 0;

  // Shadow copy of the parser state.
  hphase_t     sh_phase;
  step_t       sh_step;
  logic [1:0]  sh_zeros;
  logic [4:0]  sh_lead;
  logic [5:0]  sh_left;
  bit          sh_suffix;
  logic [31:0] sh_acc;
  logic [7:0]  sh_prof;
  logic [1:0]  sh_chroma;
  logic [31:0] sh_count;
  logic [7:0]  sh_scale;
  logic [31:0] sh_size[7];
  int          sh_list;

  task automatic add_bit(bit b);
    bitq = {bitq, b};
  endtask

  task automatic add_byte(logic [7:0] b);
    nal_q = {nal_q, b};
  endtask

  function automatic int field_bits(step_t s);
    case (s)
      ST_PROFILE, ST_CONSTRAINT, ST_LEVEL: return 8;
      ST_SEP_PLANE, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DPIC_FLAG, ST_GAPS,
      ST_FMO, ST_MBAFF, ST_DIRECT, ST_CROP_FLAG: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit has_chroma_info(logic [7:0] p);
    case (p)
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118, 8'd128,
      8'd138, 8'd139, 8'd134, 8'd135: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic enter_step(step_t s);
    sh_step = s;
    sh_acc = 32'd0;
    sh_lead = 5'd0;
    sh_suffix = 0;
    sh_left = 6'(field_bits(s));
  endtask

  task automatic next_matrix();
    int count;
    count = (sh_chroma != 2'd3) ? 8 : 12;
    sh_list++;
    enter_step(sh_list < count ? ST_LIST_FLAG : ST_LOG2_FN);
  endtask

  task automatic restart_nal();
    sh_phase = HP_START;
    sh_zeros = 2'd0;
    sh_prof = 8'd0;
    sh_chroma = 2'd1;
    sh_count = 32'd0;
    sh_scale = SCALE_INIT;
    sh_list = 0;
    for (int i = 0; i < 7; i++) sh_size[i] = 32'd0;
    enter_step(ST_PROFILE);
  endtask

  task automatic syntax_value(logic [31:0] v);
    logic [32:0] mag;
    logic [7:0]  d8;
    logic [7:0]  nx;
    case (sh_step)
      ST_PROFILE: begin sh_prof = v[7:0]; enter_step(ST_CONSTRAINT); end
      ST_CONSTRAINT: enter_step(ST_LEVEL);
      ST_LEVEL: enter_step(ST_SPS_ID);
      ST_SPS_ID: enter_step(has_chroma_info(sh_prof) ? ST_CHROMA : ST_LOG2_FN);
      ST_CHROMA: begin
        sh_chroma = (v > 32'd3) ? 2'd0 : v[1:0];
        enter_step(sh_chroma == 2'd3 ? ST_SEP_PLANE : ST_DEPTH_L);
      end
      ST_SEP_PLANE: enter_step(ST_DEPTH_L);
      ST_DEPTH_L: enter_step(ST_DEPTH_C);
      ST_DEPTH_C: enter_step(ST_BYPASS);
      ST_BYPASS: enter_step(ST_MATRIX);
      ST_MATRIX: begin
        sh_list = 0;
        enter_step(v != 0 ? ST_LIST_FLAG : ST_LOG2_FN);
      end
      ST_LIST_FLAG: begin
        if (v != 0) begin
          sh_scale = SCALE_INIT;
          sh_count = 32'd0;
          enter_step(ST_DELTA);
        end else begin
          next_matrix();
        end
      end
      ST_DELTA: begin
        // Signed Exp-Golomb mapping, then the scale wraps modulo 256.
        mag = v[0] ? ({1'b0, v} + 33'd1) >> 1 : {1'b0, v} >> 1;
        d8 = v[0] ? mag[7:0] : 8'd0 - mag[7:0];
        nx = sh_scale + d8;
        if (nx != 0) sh_scale = nx;
        sh_count++;
        if (nx == 0 || sh_count >= ((sh_list < 6) ? 32'd16 : 32'd64)) next_matrix();
        else enter_step(ST_DELTA);
      end
      ST_LOG2_FN: enter_step(ST_POC_TYPE);
      ST_POC_TYPE: enter_step(v == 0 ? ST_POC_LSB : (v == 1 ? ST_DPIC_FLAG : ST_MAX_REF));
      ST_POC_LSB: enter_step(ST_MAX_REF);
      ST_DPIC_FLAG: enter_step(ST_OFF_NONREF);
      ST_OFF_NONREF: enter_step(ST_OFF_TB);
      ST_OFF_TB: enter_step(ST_CYCLE_N);
      ST_CYCLE_N: begin
        sh_count = v;
        enter_step(v == 0 ? ST_MAX_REF : ST_CYCLE_OFF);
      end
      ST_CYCLE_OFF: begin
        sh_count--;
        enter_step(sh_count == 0 ? ST_MAX_REF : ST_CYCLE_OFF);
      end
      ST_MAX_REF: enter_step(ST_GAPS);
      ST_GAPS: enter_step(ST_WIDTH);
      ST_WIDTH: begin sh_size[0] = v; enter_step(ST_HEIGHT); end
      ST_HEIGHT: begin sh_size[1] = v; enter_step(ST_FMO); end
      ST_FMO: begin sh_size[2] = {31'd0, v[0]}; enter_step(v != 0 ? ST_DIRECT : ST_MBAFF); end
      ST_MBAFF: enter_step(ST_DIRECT);
      ST_DIRECT: enter_step(ST_CROP_FLAG);
      ST_CROP_FLAG: enter_step(v != 0 ? ST_CROP_L : ST_DONE);
      ST_CROP_L: begin sh_size[3] = v; enter_step(ST_CROP_R); end
      ST_CROP_R: begin sh_size[4] = v; enter_step(ST_CROP_T); end
      ST_CROP_T: begin sh_size[5] = v; enter_step(ST_CROP_B); end
      ST_CROP_B: begin sh_size[6] = v; enter_step(ST_DONE); end
      default: sh_step = ST_DONE;
    endcase
  endtask

  task automatic parse_bit(bit b);
    if (sh_step >= ST_DONE) return;
    if (field_bits(sh_step) != 0) begin
      sh_acc = {sh_acc[30:0], b};
      sh_left--;
      if (sh_left == 0) syntax_value(sh_acc);
    end else if (!sh_suffix) begin
      if (!b && sh_lead < GOLOMB_ZERO_CAP) sh_lead++;
      else if (sh_lead == 0) syntax_value(32'd0);
      else begin
        sh_suffix = 1;
        sh_left = {1'b0, sh_lead};
        sh_acc = 32'd0;
      end
    end else begin
      sh_acc = {sh_acc[30:0], b};
      sh_left--;
      if (sh_left == 0) syntax_value(((32'd1 << sh_lead) - 32'd1) + sh_acc);
    end
  endtask

  // Advances the shadow parser by one byte; on the last byte returns the dimensions.
  task automatic predict_dims(input logic [7:0] b, input bit last, output bit has,
                              output dims_t r);
    longint fl, sw, sh, w, h, lim;
    has = 0;
    r = '{0, 16'd0, 16'd0};
    case (sh_phase)
      HP_START: begin
        if (b != 0) sh_phase = (b[4:0] == NAL_TYPE_SPS && !last) ? HP_BODY : HP_FAIL;
        else sh_phase = HP_ZERO1;
      end
      HP_ZERO1: sh_phase = (b == 0) ? HP_ZERO2 : HP_FAIL;
      HP_ZERO2: sh_phase = (b == 1) ? HP_HEADER : (b == 0 ? HP_ZERO3 : HP_FAIL);
      HP_ZERO3: sh_phase = (b == 1) ? HP_HEADER : HP_FAIL;
      HP_HEADER: sh_phase = (b[4:0] == NAL_TYPE_SPS && !last) ? HP_BODY : HP_FAIL;
      HP_BODY: begin
        if (sh_zeros >= 2 && b == EMUL_BYTE) begin
          sh_zeros = 2'd0;
        end else begin
          sh_zeros = (b == 0) ? (sh_zeros < 2 ? sh_zeros + 2'd1 : 2'd2) : 2'd0;
          for (int i = 7; i >= 0; i--) parse_bit(b[i]);
        end
      end
      default: sh_phase = HP_FAIL;
    endcase
    if (!last) return;
    has = 1;
    if (sh_phase == HP_BODY && sh_step >= ST_CROP_L) begin
      // Missing cropping offsets read as zero bits.
      for (int i = 0; i < 512 && sh_step < ST_DONE; i++) parse_bit(0);
      if (sh_step >= ST_DONE) begin
        fl = 2 - longint'({32'd0, sh_size[2]});
        sw = (sh_chroma == 2'd1 || sh_chroma == 2'd2) ? 2 : 1;
        sh = (sh_chroma == 2'd1) ? 2 : 1;
        lim = (longint'(1) << DIM_BITS) - 1;
        w = (longint'({32'd0, sh_size[0]}) + 1) * 16;
        h = (longint'({32'd0, sh_size[1]}) + 1) * 16 * fl;
        w -= (longint'({32'd0, sh_size[3]}) + longint'({32'd0, sh_size[4]})) * sw;
        h -= (longint'({32'd0, sh_size[5]}) + longint'({32'd0, sh_size[6]})) * sh * fl;
        if (w >= 2 && h >= 2 && w <= lim && h <= lim) r = '{1, w[15:0], h[15:0]};
      end
    end
    restart_nal();
  endtask

  task automatic add_row(logic [7:0] b, bit last, bit typed = 0, bit eok = 0,
                         int ew = 0, int eh = 0);
    row_t r;
    r.b = b;
    r.last = last;
    r.typed = typed;
    r.res = '{eok, 16'(ew), 16'(eh)};
    dir_rows = {dir_rows, r};
  endtask

  task automatic put_bits(longint v, int n);
    for (int i = n - 1; i >= 0; i--) add_bit(v[i]);
  endtask

  task automatic put_ue(longint v);
    longint x;
    int len;
    x = v + 1;
    len = 0;
    while ((x >> len) != 0) len++;
    repeat (len - 1) add_bit(1'b0);
    put_bits(x, len);
  endtask

  task automatic put_se(int s);
    put_ue(s > 0 ? 2 * longint'(s) - 1 : -2 * longint'(s));
  endtask

  function automatic int small_se();
    return int'($urandom_range(0, 16)) - 8;
  endfunction

  // Builds one SPS NAL with random content into nal_q, escapes included; the start code may be absent or bad.
  task automatic build_sps();
    logic [7:0] prof;
    int cf, poc, n, lists, lsize, last, d, nx, zc, cut;
    logic [7:0] by;
    bitq.delete();
    nal_q.delete();
    case ($urandom_range(0, 3))
      0: prof = 8'd66;
      1: prof = 8'd77;
      2: prof = 8'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: prof = 8'd100;
          1: prof = 8'd244;
          2: prof = 8'd44;
          default: prof = 8'd135;
        endcase
      end
    endcase
    put_bits(prof, 8);
    put_bits($urandom_range(0, 255), 8);
    put_bits($urandom_range(0, 255), 8);
    put_ue($urandom_range(0, 31));
    if (has_chroma_info(prof)) begin
      cf = $urandom_range(0, 4);
      put_ue(cf);
      if (cf == 3) add_bit(1'($urandom_range(0, 1)));
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      add_bit(1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 2) == 0);
      add_bit(n != 0);
      if (n) begin
        lists = (cf == 3) ? 12 : 8;
        for (int li = 0; li < lists; li++) begin
          n = ($urandom_range(0, 3) == 0);
          add_bit(n != 0);
          if (n) begin
            lsize = (li < 6) ? 16 : 64;
            last = 8;
            for (int j = 0; j < lsize; j++) begin
              d = ($urandom_range(0, 3) == 0) ? -last : small_se();
              put_se(d);
              nx = (last + d) & 255;
              if (nx == 0) break;
              last = nx;
            end
          end
        end
      end
    end
    put_ue($urandom_range(0, 12));
    poc = $urandom_range(0, 3);
    put_ue(poc);
    if (poc == 0) begin
      put_ue($urandom_range(0, 12));
    end else if (poc == 1) begin
      add_bit(1'($urandom_range(0, 1)));
      put_se(small_se());
      put_se(small_se());
      n = $urandom_range(0, 3);
      put_ue(n);
      repeat (n) put_se(small_se());
    end
    put_ue($urandom_range(0, 16));
    add_bit(1'($urandom_range(0, 1)));
    put_ue($urandom_range(0, 4) == 0 ? $urandom_range(0, 4200) : $urandom_range(0, 120));
    put_ue($urandom_range(0, 4) == 0 ? $urandom_range(0, 4200) : $urandom_range(0, 120));
    n = $urandom_range(0, 1);
    add_bit(n != 0);
    if (!n) add_bit(1'($urandom_range(0, 1)));
    add_bit(1'($urandom_range(0, 1)));
    n = $urandom_range(0, 1);
    add_bit(n != 0);
    if (n) begin
      repeat (4) put_ue($urandom_range(0, 5) == 0 ? $urandom_range(0, 2100)
                                                  : $urandom_range(0, 8));
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, bitq.size());
      while (bitq.size() > cut) void'(bitq.pop_back());
    end else begin
      repeat ($urandom_range(0, 20)) add_bit(1'($urandom_range(0, 1)));
      add_bit(1'b1);
    end
    while (bitq.size() % 8 != 0) add_bit(1'b0);
    case ($urandom_range(0, 14))
      0, 1, 2, 3, 4: ;
      5, 6, 7, 8, 9: begin add_byte(8'h00); add_byte(8'h00); add_byte(8'h01); end
      10, 11, 12, 13: begin
        add_byte(8'h00); add_byte(8'h00);
        add_byte(8'h00); add_byte(8'h01);
      end
      default: begin add_byte(8'h00); add_byte(8'h00); add_byte(8'h05); end
    endcase
    by = {3'($urandom_range(0, 7)), ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                               : NAL_TYPE_SPS};
    add_byte(by);
    zc = 0;
    for (int i = 0; i < bitq.size(); i += 8) begin
      for (int k = 0; k < 8; k++) by[7 - k] = bitq[i + k];
      if (zc >= 2 && by <= 8'd3) begin
        add_byte(EMUL_BYTE);
        zc = 0;
      end
      add_byte(by);
      zc = (by == 0) ? zc + 1 : 0;
    end
  endtask

  task automatic send_beat(logic [7:0] b, bit last, bit typed, dims_t typed_res);
    bit has;
    dims_t r;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    nal_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    predict_dims(b, last, has, r);
    if (has) begin
      if (typed) r = typed_res;
      dims_q = {dims_q, r};
    end
  endtask

  initial begin
    int nals;
    int len;
    restart_nal();
    // Header-only, bad start code, wrong type, then a minimal valid SPS unit.
    add_row(8'h67, 1, 1, 0, 0, 0);
    add_row(8'h00, 1, 1, 0, 0, 0);
    add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h02, 1, 1, 0, 0, 0);
    add_row(8'h68, 0); add_row(8'h00, 1, 1, 0, 0, 0);
    add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0); add_row(8'h67, 0);
    add_row(8'h42, 0); add_row(8'h00, 0); add_row(8'h1E, 0); add_row(8'hDD, 0);
    add_row(8'hC0, 1, 1, 1, 16, 16);
    // Truncated before the cropping flag.
    add_row(8'h67, 0); add_row(8'h42, 0); add_row(8'h00, 1, 1, 0, 0, 0);
    // High profile with an escaped zero run and a long Golomb prefix.
    add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h01, 0);
    add_row(8'hE7, 0); add_row(8'h64, 0); add_row(8'hFF, 0); add_row(8'h00, 0);
    add_row(8'h00, 0); add_row(8'h03, 0); add_row(8'h00, 0); add_row(8'h80, 1);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                                    dir_rows[i].res);
    nals = 0;
    while ((bytes_sent < 950 || results_seen + dims_q.size() < 40) && nals < 400) begin
      nals++;
      if (nals == 12) hold_req = 1;
      if (nals == 30) begin
        in_valid <= 1'b0;
        while (dims_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
      end
      if (bytes_sent > 800) quiet = 1;
      if ($urandom_range(0, 9) < 7) begin
        build_sps();
      end else begin
        nal_q.delete();
        len = $urandom_range(1, 12);
        repeat (len) begin
          case ($urandom_range(0, 4))
            0: add_byte(8'h00);
            1: add_byte(8'h03);
            2: add_byte(8'h67);
            default: add_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
      foreach (nal_q[i]) send_beat(nal_q[i], i == nal_q.size() - 1, 0, '{0, 16'd0, 16'd0});
    end
    in_valid <= 1'b0;
    while (dims_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    @(negedge rst);
    forever begin
      if (hold_req) begin
        // Long hold-off so the input queue fills and the block stalls its input.
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dims_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (dims_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: ok=%0d w=%0d h=%0d",
                                   ok, luma_width, luma_height);
      end else begin
        e = dims_q.pop_front();
        if (ok !== e.ok || luma_width !== e.w || luma_height !== e.h) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected ok=%0d w=%0d h=%0d, got ok=%0d w=%0d h=%0d",
                     e.ok, e.w, e.h, ok, luma_width, luma_height);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
